/* sv/wtsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared types and constants of the world-to-screen projection block.
// ----------------------------------------------------------------------------
package wtsp_pkg;

	localparam int UNIT_BITS = 28;
	localparam int NUM_REGS  = 8;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_CAMERA_X   = 3'd0;
	localparam reg_idx_t REG_CAMERA_Y   = 3'd1;
	localparam reg_idx_t REG_CAMERA_Z   = 3'd2;
	localparam reg_idx_t REG_FACING_X   = 3'd3;
	localparam reg_idx_t REG_FACING_Y   = 3'd4;
	localparam reg_idx_t REG_FACING_Z   = 3'd5;
	localparam reg_idx_t REG_FOCAL      = 3'd6;
	localparam reg_idx_t REG_SCREEN     = 3'd7;

	localparam logic [31:0] RST_FACING_Z = 32'd65536;
	localparam logic [31:0] RST_FOCAL    = 32'd65536;
	localparam logic [31:0] RST_SCREEN   = 32'd70780800;

	// Camera basis, each component signed Q.28
	typedef struct packed {
		logic signed [31:0] f0;
		logic signed [31:0] f1;
		logic signed [31:0] f2;
		logic signed [31:0] r0;
		logic signed [31:0] r2;
		logic signed [31:0] u0;
		logic signed [31:0] u1;
		logic signed [31:0] u2;
	} basis_t;

	// Shift right by the unit bits, round half away from zero
	function automatic logic signed [31:0] round_unit(input logic signed [63:0] v);
		logic [63:0] m;
		m = v[63] ? (~v + 64'd1) : v;
		m = (m + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
		return v[63] ? (~m[31:0] + 32'd1) : m[31:0];
	endfunction

endpackage

/* sv/wtsp_basis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_basis
// Sequential unit that builds the unit camera basis from the facing vector:
// scale, sum of squares, bitwise square root, restoring divide, cross product.
// ----------------------------------------------------------------------------
module wtsp_basis (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                restart,
	input  logic signed [31:0]  facing_x,
	input  logic signed [31:0]  facing_y,
	input  logic signed [31:0]  facing_z,
	output wtsp_pkg::basis_t    basis,
	output logic                busy
);
	import wtsp_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD, ST_CHECK, ST_SCALE, ST_SQUARE, ST_ROOT,
		ST_DIVIDE, ST_NEXT, ST_CROSS, ST_DONE
	} state_t;

	state_t             state_q;
	logic               pass_q;
	logic [1:0]         idx_q;
	logic [6:0]         cnt_q;
	logic [31:0]        mag_q [3];
	logic               neg_q [3];
	logic signed [31:0] vec_q [3];
	logic [63:0]        acc_q, root_q, num_q, rem_q, quo_q;
	basis_t             basis_q;

	logic [31:0]        mag_or;
	logic [63:0]        square;
	logic [63:0]        root_bit, root_try;
	logic [63:0]        rem_n, quo_n;
	logic               rem_ge;
	logic [31:0]        quo_s;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;

	always_comb begin
		mag_or   = mag_q[0] | mag_q[1] | mag_q[2];
		square   = 64'(mag_q[idx_q]) * 64'(mag_q[idx_q]);
		root_bit = 64'd1 << (6'd62 - {cnt_q[4:0], 1'b0});
		root_try = root_q + root_bit;
		rem_n    = {rem_q[62:0], num_q[63]};
		rem_ge   = rem_n >= root_q;
		quo_n    = {quo_q[62:0], rem_ge};
		quo_s    = neg_q[idx_q] ? (~quo_n[31:0] + 32'd1) : quo_n[31:0];
		case (idx_q)
			2'd0: begin
				mul_a = basis_q.f1; mul_b = basis_q.r2;
			end
			2'd1: begin
				mul_a = basis_q.f2; mul_b = basis_q.r0;
			end
			2'd2: begin
				mul_a = basis_q.f0; mul_b = basis_q.r2;
			end
			default: begin
				mul_a = basis_q.f1; mul_b = basis_q.r0;
			end
		endcase
		prod = 64'(mul_a) * 64'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pass_q  <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			root_q  <= '0;
			num_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			basis_q <= '0;
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= '0;
				neg_q[i] <= 1'b0;
				vec_q[i] <= '0;
			end
		end else if (restart) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					pass_q   <= 1'b0;
					mag_q[0] <= facing_x[31] ? (~facing_x + 32'd1) : facing_x;
					mag_q[1] <= facing_y[31] ? (~facing_y + 32'd1) : facing_y;
					mag_q[2] <= facing_z[31] ? (~facing_z + 32'd1) : facing_z;
					neg_q[0] <= facing_x[31];
					neg_q[1] <= facing_y[31];
					neg_q[2] <= facing_z[31];
					state_q  <= ST_CHECK;
				end
				ST_CHECK: begin
					if (mag_or == '0) begin
						// zero vector: fall back to the axis default
						vec_q[0] <= pass_q ? (32'sd1 <<< UNIT_BITS) : 32'sd0;
						vec_q[1] <= 32'sd0;
						vec_q[2] <= pass_q ? 32'sd0 : (32'sd1 <<< UNIT_BITS);
						state_q  <= ST_NEXT;
					end else begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (mag_or[31:30] == 2'b00) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end else begin
						acc_q   <= '0;
						idx_q   <= '0;
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					acc_q <= acc_q + square;
					if (idx_q == 2'd2) begin
						root_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_ROOT;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				ST_ROOT: begin
					if (acc_q >= root_try) begin
						acc_q  <= acc_q - root_try;
						root_q <= (root_q >> 1) + root_bit;
					end else begin
						root_q <= root_q >> 1;
					end
					if (cnt_q == 7'd31) begin
						cnt_q   <= '0;
						idx_q   <= '0;
						state_q <= ST_DIVIDE;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_DIVIDE: begin
					if (cnt_q == 7'd0) begin
						num_q <= (64'(mag_q[idx_q]) << UNIT_BITS) + (root_q >> 1);
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= 7'd1;
					end else begin
						num_q <= num_q << 1;
						rem_q <= rem_ge ? (rem_n - root_q) : rem_n;
						quo_q <= quo_n;
						if (cnt_q == 7'd64) begin
							vec_q[idx_q] <= quo_s;
							cnt_q        <= '0;
							if (idx_q == 2'd2) state_q <= ST_NEXT;
							else idx_q <= idx_q + 2'd1;
						end else begin
							cnt_q <= cnt_q + 7'd1;
						end
					end
				end
				ST_NEXT: begin
					if (!pass_q) begin
						basis_q.f0 <= vec_q[0];
						basis_q.f1 <= vec_q[1];
						basis_q.f2 <= vec_q[2];
						// right axis is (f.z, 0, -f.x)
						mag_q[0] <= vec_q[2][31] ? (~vec_q[2] + 32'd1) : vec_q[2];
						neg_q[0] <= vec_q[2][31];
						mag_q[1] <= '0;
						neg_q[1] <= 1'b0;
						mag_q[2] <= vec_q[0][31] ? (~vec_q[0] + 32'd1) : vec_q[0];
						neg_q[2] <= !vec_q[0][31];
						pass_q   <= 1'b1;
						state_q  <= ST_CHECK;
					end else begin
						basis_q.r0 <= vec_q[0];
						basis_q.r2 <= vec_q[2];
						idx_q      <= '0;
						state_q    <= ST_CROSS;
					end
				end
				ST_CROSS: begin
					case (idx_q)
						2'd0: basis_q.u0 <= round_unit(prod);
						2'd1: acc_q <= prod;
						2'd2: basis_q.u1 <= round_unit(acc_q - prod);
						default: basis_q.u2 <= round_unit(-prod);
					endcase
					if (idx_q == 2'd3) state_q <= ST_DONE;
					else idx_q <= idx_q + 2'd1;
				end
				ST_DONE: begin
					state_q <= ST_DONE;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign basis = basis_q;
	assign busy  = (state_q != ST_DONE);

endmodule

/* sv/world_to_screen_projection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Look-at perspective projection of world points to Q pixel coordinates.
// Pipeline: 9 arithmetic stages, one stage per quotient bit of the 42-bit
// divide, and one output stage.
// Throughput: one item per cycle; a stalled output freezes the whole pipe.
// After reset and after each facing write the basis unit rebuilds the basis
// (square root and three 64-step divides, twice) while the input is stalled.
// ----------------------------------------------------------------------------
module world_to_screen_projection #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  wtsp_pkg::reg_idx_t  cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [31:0]  point_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  screen_x,
	output logic signed [31:0]  screen_y,
	output logic                behind,
	output logic                visible
);
	import wtsp_pkg::*;

	localparam int DIV_BITS = 42;
	localparam int MAG_W    = 62;
	localparam int T_W      = 94;
	localparam int WV_W     = 78;
	localparam int PX_W     = 110;
	localparam int NX_W     = 111;
	localparam int HI_W     = NX_W - DIV_BITS;
	localparam int VZF_W    = MAG_W + FRACTION_BITS;
	localparam int WVF_W    = WV_W + FRACTION_BITS;
	localparam int OFS_W    = 45;
	localparam logic signed [63:0] THR =
		64'((64'd1 << (FRACTION_BITS + UNIT_BITS)) / 64'd10000);
	localparam logic [DIV_BITS-1:0] CLAMP = DIV_BITS'(1) << (DIV_BITS - 1);

	typedef struct packed {
		logic [63:0]          remx;
		logic [63:0]          remy;
		logic [DIV_BITS-1:0]  nlx;
		logic [DIV_BITS-1:0]  nly;
		logic [DIV_BITS-1:0]  qx;
		logic [DIV_BITS-1:0]  qy;
		logic [62:0]          dvs;
		logic                 clx;
		logic                 cly;
		logic                 negx;
		logic                 negy;
		logic                 bhd;
		logic                 on;
	} div_t;

	// ---------------- configuration ----------------
	logic signed [31:0] cam_q [3];
	logic signed [31:0] facing_q [3];
	logic [31:0]        focal_q, size_q;
	logic               restart;
	basis_t             bas;
	logic               bas_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) cam_q[i] <= '0;
			facing_q[0] <= '0;
			facing_q[1] <= '0;
			facing_q[2] <= RST_FACING_Z;
			focal_q     <= RST_FOCAL;
			size_q      <= RST_SCREEN;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CAMERA_X: cam_q[0]    <= cfg_data;
				REG_CAMERA_Y: cam_q[1]    <= cfg_data;
				REG_CAMERA_Z: cam_q[2]    <= cfg_data;
				REG_FACING_X: facing_q[0] <= cfg_data;
				REG_FACING_Y: facing_q[1] <= cfg_data;
				REG_FACING_Z: facing_q[2] <= cfg_data;
				REG_FOCAL:    focal_q     <= cfg_data;
				REG_SCREEN:   size_q      <= cfg_data;
				default:      focal_q     <= focal_q;
			endcase
		end
	end

	assign restart = cfg_write && (cfg_index == REG_FACING_X ||
		cfg_index == REG_FACING_Y || cfg_index == REG_FACING_Z);

	wtsp_basis u_basis (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.facing_x (facing_q[0]),
		.facing_y (facing_q[1]),
		.facing_z (facing_q[2]),
		.basis    (bas),
		.busy     (bas_busy)
	);

	logic [15:0] scr_w, scr_h;
	assign scr_w = size_q[15:0];
	assign scr_h = size_q[31:16];

	// ---------------- pipeline control ----------------
	logic adv, accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic dv_vld_s [DIV_BITS+1];

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv || bas_busy;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			for (int i = 0; i <= DIV_BITS; i++) dv_vld_s[i] <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4;   v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			dv_vld_s[0] <= v_s8;
			for (int i = 1; i <= DIV_BITS; i++) dv_vld_s[i] <= dv_vld_s[i-1];
			out_valid <= dv_vld_s[DIV_BITS];
		end
	end

	// ---------------- view transform ----------------
	logic signed [32:0] d_s1 [3];
	logic signed [63:0] px0_s2, px2_s2, py_s2 [3], pz_s2 [3];
	logic signed [63:0] vx_s3, vy_s3, vz_s3;
	logic [MAG_W-1:0]   magx_s4, magy_s4, vz_s4;
	logic               negx_s4, negy_s4, bhd_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= 33'(point_x) - 33'(cam_q[0]);
			d_s1[1] <= 33'(point_y) - 33'(cam_q[1]);
			d_s1[2] <= 33'(point_z) - 33'(cam_q[2]);

			px0_s2   <= 64'(bas.r0) * 64'(d_s1[0]);
			px2_s2   <= 64'(bas.r2) * 64'(d_s1[2]);
			py_s2[0] <= 64'(bas.u0) * 64'(d_s1[0]);
			py_s2[1] <= 64'(bas.u1) * 64'(d_s1[1]);
			py_s2[2] <= 64'(bas.u2) * 64'(d_s1[2]);
			pz_s2[0] <= 64'(bas.f0) * 64'(d_s1[0]);
			pz_s2[1] <= 64'(bas.f1) * 64'(d_s1[1]);
			pz_s2[2] <= 64'(bas.f2) * 64'(d_s1[2]);

			vx_s3 <= px0_s2 + px2_s2;
			vy_s3 <= py_s2[0] + py_s2[1] + py_s2[2];
			vz_s3 <= pz_s2[0] + pz_s2[1] + pz_s2[2];

			bhd_s4  <= vz_s3 <= THR;
			negx_s4 <= vx_s3[63];
			negy_s4 <= vy_s3[63];
			magx_s4 <= MAG_W'(vx_s3[63] ? -vx_s3 : vx_s3);
			magy_s4 <= MAG_W'(vy_s3[63] ? -vy_s3 : vy_s3);
			vz_s4   <= MAG_W'(vz_s3);
		end
	end

	// ---------------- scale products ----------------
	logic [62:0]        txl_s5, txh_s5, tyl_s5, tyh_s5;
	logic [46:0]        wvl_s5, wvh_s5;
	logic [MAG_W-1:0]   vz_s5, vz_s6, vz_s7, vz_s8;
	logic               negx_s5, negy_s5, bhd_s5;
	logic [T_W-1:0]     tx_s6, ty_s6;
	logic [WV_W-1:0]    wv_s6, wv_s7, wv_s8;
	logic               negx_s6, negy_s6, bhd_s6;
	logic [47:0]        hx0_s7, hx1_s7, hy0_s7, hy1_s7;
	logic [45:0]        hx2_s7, hy2_s7;
	logic               negx_s7, negy_s7, bhd_s7, ony_s7;
	logic [PX_W-1:0]    px_s8, py_s8;
	logic               negx_s8, negy_s8, bhd_s8, ony_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			txl_s5  <= 63'(focal_q) * 63'(magx_s4[30:0]);
			txh_s5  <= 63'(focal_q) * 63'(magx_s4[61:31]);
			tyl_s5  <= 63'(focal_q) * 63'(magy_s4[30:0]);
			tyh_s5  <= 63'(focal_q) * 63'(magy_s4[61:31]);
			wvl_s5  <= 47'(scr_w) * 47'(vz_s4[30:0]);
			wvh_s5  <= 47'(scr_w) * 47'(vz_s4[61:31]);
			vz_s5   <= vz_s4;
			negx_s5 <= negx_s4; negy_s5 <= negy_s4; bhd_s5 <= bhd_s4;

			tx_s6   <= T_W'(txl_s5) + (T_W'(txh_s5) << 31);
			ty_s6   <= T_W'(tyl_s5) + (T_W'(tyh_s5) << 31);
			wv_s6   <= WV_W'(wvl_s5) + (WV_W'(wvh_s5) << 31);
			vz_s6   <= vz_s5;
			negx_s6 <= negx_s5; negy_s6 <= negy_s5; bhd_s6 <= bhd_s5;

			hx0_s7  <= 48'(scr_h) * 48'(tx_s6[31:0]);
			hx1_s7  <= 48'(scr_h) * 48'(tx_s6[63:32]);
			hx2_s7  <= 46'(scr_h) * 46'(tx_s6[93:64]);
			hy0_s7  <= 48'(scr_h) * 48'(ty_s6[31:0]);
			hy1_s7  <= 48'(scr_h) * 48'(ty_s6[63:32]);
			hy2_s7  <= 46'(scr_h) * 46'(ty_s6[93:64]);
			ony_s7  <= ty_s6 <= T_W'(VZF_W'(vz_s6) << FRACTION_BITS);
			wv_s7   <= wv_s6;
			vz_s7   <= vz_s6;
			negx_s7 <= negx_s6; negy_s7 <= negy_s6; bhd_s7 <= bhd_s6;

			px_s8   <= PX_W'(hx0_s7) + (PX_W'(hx1_s7) << 32) + (PX_W'(hx2_s7) << 64);
			py_s8   <= PX_W'(hy0_s7) + (PX_W'(hy1_s7) << 32) + (PX_W'(hy2_s7) << 64);
			ony_s8  <= ony_s7;
			wv_s8   <= wv_s7;
			vz_s8   <= vz_s7;
			negx_s8 <= negx_s7; negy_s8 <= negy_s7; bhd_s8 <= bhd_s7;
		end
	end

	// ---------------- divide setup ----------------
	logic [NX_W-1:0]  nx, ny;
	logic [62:0]      dvs;
	logic             clx, cly;
	div_t             dv_s [DIV_BITS+1];

	always_comb begin
		// numerator gets vz added so the quotient rounds half away from zero
		nx  = NX_W'(px_s8) + NX_W'(vz_s8);
		ny  = NX_W'(py_s8) + NX_W'(vz_s8);
		dvs = {vz_s8, 1'b0};
		clx = nx[NX_W-1:DIV_BITS] >= HI_W'(dvs);
		cly = ny[NX_W-1:DIV_BITS] >= HI_W'(dvs);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0].remx <= clx ? 64'd0 : 64'(nx[NX_W-1:DIV_BITS]);
			dv_s[0].remy <= cly ? 64'd0 : 64'(ny[NX_W-1:DIV_BITS]);
			dv_s[0].nlx  <= nx[DIV_BITS-1:0];
			dv_s[0].nly  <= ny[DIV_BITS-1:0];
			dv_s[0].qx   <= '0;
			dv_s[0].qy   <= '0;
			dv_s[0].dvs  <= dvs;
			dv_s[0].clx  <= clx;
			dv_s[0].cly  <= cly;
			dv_s[0].negx <= negx_s8;
			dv_s[0].negy <= negy_s8;
			dv_s[0].bhd  <= bhd_s8;
			dv_s[0].on   <= ony_s8 && (px_s8 <= PX_W'(WVF_W'(wv_s8) << FRACTION_BITS));
		end
	end

	// ---------------- restoring divide, one quotient bit per stage ----------------
	for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
		logic [63:0] rx, ry;
		logic        gx, gy;
		div_t        nxt;
		always_comb begin
			rx = {dv_s[k-1].remx[62:0], dv_s[k-1].nlx[DIV_BITS-1]};
			ry = {dv_s[k-1].remy[62:0], dv_s[k-1].nly[DIV_BITS-1]};
			gx = rx >= 64'(dv_s[k-1].dvs);
			gy = ry >= 64'(dv_s[k-1].dvs);
			nxt      = dv_s[k-1];
			nxt.remx = gx ? (rx - 64'(dv_s[k-1].dvs)) : rx;
			nxt.remy = gy ? (ry - 64'(dv_s[k-1].dvs)) : ry;
			nxt.nlx  = dv_s[k-1].nlx << 1;
			nxt.nly  = dv_s[k-1].nly << 1;
			nxt.qx   = {dv_s[k-1].qx[DIV_BITS-2:0], gx};
			nxt.qy   = {dv_s[k-1].qy[DIV_BITS-2:0], gy};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k] <= nxt;
			end
		end
	end

	// ---------------- output stage ----------------
	function automatic logic signed [31:0] sat32(input logic signed [OFS_W-1:0] v);
		if (v > OFS_W'(64'sd2147483647)) return 32'sh7fffffff;
		if (v < OFS_W'(-64'sd2147483648)) return 32'sh80000000;
		return v[31:0];
	endfunction

	div_t                   dl;
	logic [DIV_BITS-1:0]    mx, my;
	logic signed [OFS_W-1:0] ox, oy, cx, cy;

	always_comb begin
		dl = dv_s[DIV_BITS];
		mx = (dl.clx || dl.qx > CLAMP) ? CLAMP : dl.qx;
		my = (dl.cly || dl.qy > CLAMP) ? CLAMP : dl.qy;
		ox = dl.negx ? -OFS_W'(mx) : OFS_W'(mx);
		oy = dl.negy ? -OFS_W'(my) : OFS_W'(my);
		cx = OFS_W'(scr_w) << (FRACTION_BITS - 1);
		cy = OFS_W'(scr_h) << (FRACTION_BITS - 1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			screen_x <= dl.bhd ? 32'sd0 : sat32(cx + ox);
			screen_y <= dl.bhd ? 32'sd0 : sat32(cy - oy);
			behind   <= dl.bhd;
			visible  <= dl.on && !dl.bhd;
		end
	end

	// ---------------- checks ----------------
	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && behind |-> screen_x == 32'sd0 && screen_y == 32'sd0 && !visible)
		else $error("behind item carries nonzero position or visible flag");

	a_no_entry_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bas_busy && adv |=> !v_s1)
		else $error("item entered while camera basis was being rebuilt");

	a_basis_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(bas_busy) |-> (bas.f0 != 0 || bas.f1 != 0 || bas.f2 != 0) &&
			(bas.u0 != 0 || bas.u1 != 0 || bas.u2 != 0))
		else $error("camera basis finished with a zero axis");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for world_to_screen_projection. Camera settings are
// written between phases while the pipe is empty. Each point the block
// accepts is projected by a fixed-point predictor kept in this bench. Every
// result must match the oldest pending projection in all four fields.
// ----------------------------------------------------------------------------
module tb_top;
	import wtsp_pkg::*;

	typedef struct {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic               behind_flag;
		logic               visible;
	} projection_t;

	// 2^44 / 10000, the depth at or below which a point counts as behind
	localparam longint BEHIND_LIMIT = 64'd1759218604;
	localparam longint ONE_UNIT     = 64'd1 << UNIT_BITS;

	class projection_scoreboard;
		logic [31:0]  regs [NUM_REGS];
		longint       fb [3];
		longint       rb [3];
		longint       ub [3];
		projection_t  pending_proj [$];
		int           errors;
		int           n_checked;
		int           n_behind;
		int           n_visible;

		function longint unsigned mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint round_unit_shift(longint v);
			longint unsigned m;
			m = (mag(v) + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
			return v < 0 ? -longint'(m) : longint'(m);
		endfunction

		function longint unsigned floor_sqrt(longint unsigned x);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		// Scale to unit length in Q.28; returns 0 for the zero vector
		function bit make_unit(ref longint v [3]);
			longint unsigned mx, sum, len, q;
			int i;
			mx = 0;
			for (i = 0; i < 3; i++) if (mag(v[i]) > mx) mx = mag(v[i]);
			if (mx == 0) return 0;
			while (mx < (64'd1 << 30)) begin
				for (i = 0; i < 3; i++) v[i] *= 2;
				mx *= 2;
			end
			sum = 0;
			for (i = 0; i < 3; i++) sum += mag(v[i]) * mag(v[i]);
			len = floor_sqrt(sum);
			for (i = 0; i < 3; i++) begin
				q = ((mag(v[i]) << UNIT_BITS) + len / 2) / len;
				v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
			end
			return 1;
		endfunction

		function void build_basis();
			fb[0] = longint'($signed(regs[REG_FACING_X]));
			fb[1] = longint'($signed(regs[REG_FACING_Y]));
			fb[2] = longint'($signed(regs[REG_FACING_Z]));
			if (!make_unit(fb)) fb = '{0, 0, ONE_UNIT};
			rb = '{fb[2], 0, -fb[0]};
			if (!make_unit(rb)) rb = '{ONE_UNIT, 0, 0};
			ub[0] = round_unit_shift(fb[1] * rb[2]);
			ub[1] = round_unit_shift(fb[2] * rb[0] - fb[0] * rb[2]);
			ub[2] = round_unit_shift(-(fb[1] * rb[0]));
		endfunction

		function void reset_regs();
			foreach (regs[i]) regs[i] = '0;
			regs[REG_FACING_Z] = RST_FACING_Z;
			regs[REG_FOCAL]    = RST_FOCAL;
			regs[REG_SCREEN]   = RST_SCREEN;
			pending_proj.delete();
			build_basis();
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] val);
			regs[idx] = val;
			build_basis();
		endfunction

		function longint screen_offset(logic [127:0] k, longint v, longint vz);
			logic [127:0] num, q;
			num = k * 128'(mag(v)) + 128'(vz);
			q = num / (128'(vz) << 1);
			if (q > (128'd1 << 41)) q = 128'd1 << 41;
			return v < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function logic [31:0] sat32(longint v);
			if (v > 64'sd2147483647) return 32'h7fff_ffff;
			if (v < -64'sd2147483648) return 32'h8000_0000;
			return v[31:0];
		endfunction

		function projection_t project(logic signed [31:0] px, logic signed [31:0] py,
				logic signed [31:0] pz);
			projection_t e;
			longint d [3];
			longint vx, vy, vz;
			longint unsigned w, h, t;
			logic [127:0] k, lhs, rhs;
			bit onx, ony;
			t = 64'(regs[REG_FOCAL]);
			w = 64'(regs[REG_SCREEN][15:0]);
			h = 64'(regs[REG_SCREEN][31:16]);
			d[0] = longint'(px) - longint'($signed(regs[REG_CAMERA_X]));
			d[1] = longint'(py) - longint'($signed(regs[REG_CAMERA_Y]));
			d[2] = longint'(pz) - longint'($signed(regs[REG_CAMERA_Z]));
			vx = rb[0] * d[0] + rb[2] * d[2];
			vy = ub[0] * d[0] + ub[1] * d[1] + ub[2] * d[2];
			vz = fb[0] * d[0] + fb[1] * d[1] + fb[2] * d[2];
			if (vz <= BEHIND_LIMIT) begin
				e = '{32'sd0, 32'sd0, 1'b1, 1'b0};
				return e;
			end
			k = 128'(h * t);
			e.sx = sat32(longint'(w << 15) + screen_offset(k, vx, vz));
			e.sy = sat32(longint'(h << 15) - screen_offset(k, vy, vz));
			lhs = k * 128'(mag(vx));
			rhs = 128'(w << 16) * 128'(vz);
			onx = lhs <= rhs;
			lhs = 128'(t) * 128'(mag(vy));
			rhs = 128'(vz) << 16;
			ony = lhs <= rhs;
			e.behind_flag = 1'b0;
			e.visible = onx && ony;
			return e;
		endfunction

		function void note_point(logic signed [31:0] px, logic signed [31:0] py,
				logic signed [31:0] pz);
			pending_proj.push_back(project(px, py, pz));
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			$display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
			errors++;
		endtask

		task check_result(projection_t got);
			projection_t want;
			if (pending_proj.size() == 0) begin
				report("unexpected item", got.sx, 32'h0);
				return;
			end
			want = pending_proj.pop_front();
			n_checked++;
			if (want.behind_flag) n_behind++;
			if (want.visible) n_visible++;
			if (got.sx !== want.sx) report("screen_x", got.sx, want.sx);
			if (got.sy !== want.sy) report("screen_y", got.sy, want.sy);
			if (got.behind_flag !== want.behind_flag)
				report("behind", 32'(got.behind_flag), 32'(want.behind_flag));
			if (got.visible !== want.visible)
				report("visible", 32'(got.visible), 32'(want.visible));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	reg_idx_t           cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic               behind;
	logic               visible;

	projection_scoreboard sb;
	bit          gaps_on;
	bit          hold_req;
	int          n_settings;
	logic [31:0] cam [3];

	world_to_screen_projection u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.screen_x  (screen_x),
		.screen_y  (screen_y),
		.behind    (behind),
		.visible   (visible)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_top failed");
		$finish;
	end

	always @(posedge clk) begin
		projection_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{screen_x, screen_y, behind, visible};
			sb.check_result(got);
		end
	end

	// Receiver: random stall bursts, or one long hold-off on request
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x  <= x;
		point_y  <= y;
		point_z  <= z;
		do @(posedge clk); while (in_stall);
		sb.note_point(x, y, z);
	endtask

	// Hold the sender until every pending projection has come back
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_proj.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller drops it after the last write
	task write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task apply_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
			logic [31:0] focal, logic [31:0] screen);
		drain();
		write_reg(REG_CAMERA_X, cx);
		write_reg(REG_CAMERA_Y, cy);
		write_reg(REG_CAMERA_Z, cz);
		write_reg(REG_FACING_X, fx);
		write_reg(REG_FACING_Y, fy);
		write_reg(REG_FACING_Z, fz);
		write_reg(REG_FOCAL, focal);
		write_reg(REG_SCREEN, screen);
		cfg_write <= 1'b0;
		cam = '{cx, cy, cz};
		n_settings++;
	endtask

	function logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			2: return $urandom_range(0, 1 << 22) - (1 << 21);
			default: return $urandom_range(0, 1 << 21) - (1 << 20);
		endcase
	endfunction

	function logic [31:0] rand_facing();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h0;
			2: return $urandom_range(0, 1 << 10) - (1 << 9);
			default: return $urandom_range(0, 1 << 18) - (1 << 17);
		endcase
	endfunction

	// Mostly points near the camera, so many land on the screen
	task send_random_point();
		if ($urandom_range(0, 4) == 0)
			send_point(rand_coord(), rand_coord(), rand_coord());
		else
			send_point(cam[0] + ($urandom_range(0, 1 << 21) - (1 << 20)),
				cam[1] + ($urandom_range(0, 1 << 21) - (1 << 20)),
				cam[2] + ($urandom_range(0, 1 << 21) - (1 << 20)));
	endtask

	task random_camera();
		logic [31:0] screen, focal;
		screen = $urandom_range(0, 3) == 0 ? ($urandom | 32'h0001_0000)
			: {16'($urandom_range(1, 4096)), 16'($urandom_range(0, 4096))};
		focal = $urandom_range(0, 4) == 0 ? $urandom_range(1, 32'hffff_ffff)
			: $urandom_range(1 << 14, 1 << 19);
		apply_camera(rand_coord(), rand_coord(), rand_coord(),
			rand_facing(), rand_facing(), rand_facing(), focal, screen);
	endtask

	initial begin
		sb = new();
		sb.reset_regs();
		cam = '{32'h0, 32'h0, 32'h0};
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_CAMERA_X;
		cfg_data  = '0;
		in_valid  = 1'b0;
		point_x   = '0;
		point_y   = '0;
		point_z   = '0;
		gaps_on   = 0;
		hold_req  = 0;
		n_settings = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset camera: center, depth threshold, edges, extremes
		send_point(32'h0, 32'h0, 32'h0001_0000);
		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'h0, 32'h0, 32'hffff_0000);
		send_point(32'h0, 32'h0, 32'd6);
		send_point(32'h0, 32'h0, 32'd7);
		send_point(32'h0001_c71c, 32'h0001_0000, 32'h0001_0000);
		send_point(32'hfffe_38e4, 32'hffff_0000, 32'h0001_0000);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'd7);

		// Zero width, facing straight up
		apply_camera(32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
			32'h0001_0000, 32'h0438_0000);
		send_point(32'h0, 32'h0001_0000, 32'h0);
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0);
		// Zero facing, smallest screen and focal
		apply_camera(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
			32'h1, 32'h0001_0001);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		// Facing straight down, largest screen and focal
		apply_camera(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h8000_0000,
			32'h0, 32'hffff_ffff, 32'hffff_ffff);
		send_point(32'h7fff_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_point(32'h8000_0000, 32'h0, 32'h8000_0000);
		// Most negative facing on every axis
		apply_camera(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h0001_0000, 32'h0438_0780);
		send_point(32'hfff0_0000, 32'hfff0_0000, 32'hfff0_0000);
		send_point(32'h0010_0000, 32'hfff0_0000, 32'hfff0_0000);

		gaps_on = 1;
		for (int p = 0; p < 12; p++) begin
			random_camera();
			if (p == 5) hold_req = 1;
			repeat (p == 5 ? 60 : 30) send_random_point();
		end

		gaps_on = 0;
		random_camera();
		repeat (90) send_random_point();

		drain();
		$display("projected %0d points over %0d camera settings", sb.n_checked, n_settings);
		$display("%0d behind the camera, %0d visible", sb.n_behind, sb.n_visible);
		if (sb.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
